>>> hw/rtl/assert_macros.svh
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is asserted
`define NMDC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion, also checked during reset
`define NMDC_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/nmdc_pkg.sv
// shared types and constants for the transcript block nmd check
`timescale 1ns / 1ps

package nmdc_pkg;

  localparam int unsigned MaxExonsDef   = 4096;
  localparam int unsigned QueueDepthDef = 2;

  localparam int unsigned CfgW   = 16;
  localparam int unsigned PosW   = 31;
  localparam int unsigned SumW   = 32;
  localparam int unsigned AmtW   = 33;
  localparam int unsigned GapW   = 34;
  localparam int unsigned CountW = 13;

  localparam logic [CfgW-1:0] NmdMinReset    = 16'd55;
  localparam logic [CfgW-1:0] IntronGapReset = 16'd16;

  localparam logic signed [GapW-1:0] GapOne   = 34'sd1;
  localparam logic signed [GapW-1:0] GapTwo   = 34'sd2;
  localparam logic signed [GapW-1:0] GapThree = 34'sd3;

  typedef enum logic [0:0] {
    CfgNmdMinBases  = 1'b0,
    CfgIntronMinGap = 1'b1
  } cfg_idx_e;

  // one classified block, handed from front to back
  typedef struct packed {
    logic            first;
    logic            last;
    logic            strand;
    logic            coding;
    logic            shift;
    logic            stop;
    logic            exon;
    logic            intron_plus;
    logic            intron_minus;
    logic [AmtW-1:0] amt;
  } entry_t;

endpackage

>>> hw/rtl/nmdc_front.sv
// front end: accepts blocks, tracks transcript context and classifies gaps
`timescale 1ns / 1ps

module nmdc_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [nmdc_pkg::PosW-1:0]    transcript_start_i,
  input  logic [nmdc_pkg::PosW-1:0]    coding_start_i,
  input  logic [nmdc_pkg::PosW-1:0]    coding_end_i,
  input  logic                         plus_strand_i,
  input  logic [nmdc_pkg::PosW-1:0]    block_offset_i,
  input  logic [nmdc_pkg::PosW-1:0]    block_size_i,
  input  logic                         last_block_i,
  input  logic [nmdc_pkg::CfgW-1:0]    intron_min_gap_i,
  output logic                         entry_valid_o,
  input  logic                         entry_ready_i,
  output nmdc_pkg::entry_t             entry_o
);

  // transcript context
  logic                      mid_q;
  logic [nmdc_pkg::PosW-1:0] hs_q, cs_q, ce_q;
  logic                      strand_q;
  logic [nmdc_pkg::SumW-1:0] prev_q;

  // stage one registers
  logic                             s1_valid_q;
  logic                             s1_first_q, s1_last_q, s1_strand_q, s1_coding_q;
  logic [nmdc_pkg::PosW-1:0]        s1_cs_q, s1_ce_q;
  logic [nmdc_pkg::SumW-1:0]        s1_s_q;
  logic [nmdc_pkg::AmtW-1:0]        s1_e_q;
  logic [nmdc_pkg::AmtW-1:0]        s1_gstart_q;
  logic signed [nmdc_pkg::GapW-1:0] s1_gap_q;

  logic                      accept;
  logic [nmdc_pkg::PosW-1:0] cur_hs, cur_cs, cur_ce;
  logic                      cur_strand;
  logic [nmdc_pkg::SumW-1:0] rel_end;

  assign in_ready_o = !s1_valid_q || entry_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign cur_hs     = mid_q ? hs_q : transcript_start_i;
  assign cur_cs     = mid_q ? cs_q : coding_start_i;
  assign cur_ce     = mid_q ? ce_q : coding_end_i;
  assign cur_strand = mid_q ? strand_q : plus_strand_i;
  assign rel_end    = {1'b0, block_offset_i} + {1'b0, block_size_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q      <= 1'b0;
      hs_q       <= '0;
      cs_q       <= '0;
      ce_q       <= '0;
      strand_q   <= 1'b0;
      prev_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        mid_q    <= !last_block_i;
        hs_q     <= cur_hs;
        cs_q     <= cur_cs;
        ce_q     <= cur_ce;
        strand_q <= cur_strand;
        prev_q   <= rel_end;
        s1_valid_q <= 1'b1;
      end else if (entry_ready_i) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_first_q  <= !mid_q;
      s1_last_q   <= last_block_i;
      s1_strand_q <= cur_strand;
      s1_coding_q <= cur_cs < cur_ce;
      s1_cs_q     <= cur_cs;
      s1_ce_q     <= cur_ce;
      s1_s_q      <= {1'b0, cur_hs} + {1'b0, block_offset_i};
      s1_e_q      <= {2'b0, cur_hs} + {1'b0, rel_end};
      s1_gstart_q <= {2'b0, cur_hs} + {1'b0, prev_q};
      s1_gap_q    <= $signed({3'b0, block_offset_i}) - $signed({2'b0, prev_q});
    end
  end

  // stage two: gap classes and base contribution
  logic                      small_gap, is_shift, is_stop, big_gap;
  logic [nmdc_pkg::SumW-1:0] lo;
  logic [nmdc_pkg::AmtW-1:0] hi, amt_plus, amt_minus;

  always_comb begin
    is_shift  = (s1_gap_q == nmdc_pkg::GapOne) || (s1_gap_q == nmdc_pkg::GapTwo);
    is_stop   = s1_gap_q == nmdc_pkg::GapThree;
    small_gap = is_shift || is_stop;
    big_gap   = s1_gap_q > $signed({18'd0, intron_min_gap_i});

    lo = (s1_s_q > {1'b0, s1_ce_q}) ? s1_s_q : {1'b0, s1_ce_q};
    amt_plus = (s1_e_q > {1'b0, lo}) ? s1_e_q - {1'b0, lo} : '0;
    hi = (s1_e_q < {2'b0, s1_cs_q}) ? s1_e_q : {2'b0, s1_cs_q};
    amt_minus = (hi > {1'b0, s1_s_q}) ? hi - {1'b0, s1_s_q} : '0;

    entry_o.first        = s1_first_q;
    entry_o.last         = s1_last_q;
    entry_o.strand       = s1_strand_q;
    entry_o.coding       = s1_coding_q;
    entry_o.shift        = !s1_first_q && is_shift;
    entry_o.stop         = !s1_first_q && is_stop;
    entry_o.exon         = !s1_first_q && !small_gap;
    entry_o.intron_plus  = !s1_first_q && big_gap && s1_strand_q &&
                           ({2'b0, s1_ce_q} < s1_gstart_q);
    entry_o.intron_minus = !s1_first_q && big_gap && !s1_strand_q &&
                           ({1'b0, s1_s_q} < {2'b0, s1_cs_q});
    entry_o.amt          = s1_strand_q ? amt_plus : amt_minus;
  end

  assign entry_valid_o = s1_valid_q;

endmodule

>>> hw/rtl/nmdc_queue.sv
// short queue of classified blocks between front and back
`timescale 1ns / 1ps

module nmdc_queue #(
  parameter int unsigned Depth = nmdc_pkg::QueueDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  nmdc_pkg::entry_t push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output nmdc_pkg::entry_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  nmdc_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             push, pop;

  assign push_ready_o = cnt_q != FullCnt;
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

>>> hw/rtl/nmdc_back.sv
// back end: running base sums, gap flags, exon tally and result register
`timescale 1ns / 1ps

module nmdc_back #(
  parameter int unsigned MaxExons = nmdc_pkg::MaxExonsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          entry_valid_i,
  output logic                          entry_ready_o,
  input  nmdc_pkg::entry_t              entry_i,
  input  logic [nmdc_pkg::CfgW-1:0]     nmd_min_bases_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          nmd_target_o,
  output logic                          frame_shift_o,
  output logic                          genomic_stop_o,
  output logic [nmdc_pkg::CountW-1:0]   exon_count_o
);

  localparam int unsigned TallyW = $clog2(MaxExons + 1);
  localparam logic [TallyW-1:0] TallyMax = TallyW'(MaxExons);
  localparam logic [TallyW-1:0] TallyOne = TallyW'(1);

  logic [nmdc_pkg::SumW-1:0] tail_q, tail_d, snap_q, snap_d, head_q, head_d;
  logic                      fis_q, fis_d, shift_q, shift_d, stop_q, stop_d;
  logic [TallyW-1:0]         tally_q, tally_d;

  logic                           out_valid_q;
  logic                           nmd_q, fs_q, gs_q;
  logic [nmdc_pkg::CountW-1:0]    cnt_q;

  logic                           pop, nmd_d;
  logic [nmdc_pkg::SumW-1:0]      tail_b, head_b;
  logic [nmdc_pkg::SumW+1:0]      tail_sum, head_sum;
  logic [nmdc_pkg::SumW-1:0]      bases;
  logic [TallyW+nmdc_pkg::CountW-1:0] tally_ext;

  assign entry_ready_o = !entry_i.last || !out_valid_q || out_ready_i;
  assign pop           = entry_valid_i && entry_ready_o;

  always_comb begin
    tail_b  = entry_i.first ? '0 : tail_q;
    head_b  = entry_i.first ? '0 : head_q;
    snap_d  = entry_i.first ? '0 : snap_q;
    fis_d   = entry_i.first ? 1'b0 : fis_q;
    shift_d = (entry_i.first ? 1'b0 : shift_q) || entry_i.shift;
    stop_d  = (entry_i.first ? 1'b0 : stop_q) || entry_i.stop;
    tally_d = entry_i.first ? TallyOne : tally_q;
    if (entry_i.exon && tally_d < TallyMax) begin
      tally_d = tally_d + TallyW'(1);
    end

    if (entry_i.intron_plus) begin
      snap_d = tail_b;
      fis_d  = 1'b1;
    end
    if (entry_i.intron_minus) begin
      fis_d = 1'b1;
    end

    tail_sum = {2'b0, tail_b} + {1'b0, entry_i.amt};
    head_sum = {2'b0, head_b} + {1'b0, entry_i.amt};
    tail_d   = tail_b;
    head_d   = head_b;
    if (entry_i.strand) begin
      tail_d = (tail_sum[nmdc_pkg::SumW+1:nmdc_pkg::SumW] != 2'b0) ? '1
             : tail_sum[nmdc_pkg::SumW-1:0];
    end else if (fis_d) begin
      head_d = (head_sum[nmdc_pkg::SumW+1:nmdc_pkg::SumW] != 2'b0) ? '1
             : head_sum[nmdc_pkg::SumW-1:0];
    end

    bases     = entry_i.strand ? snap_d : head_d;
    nmd_d     = entry_i.coding && fis_d && (bases >= {16'd0, nmd_min_bases_i});
    tally_ext = {{nmdc_pkg::CountW{1'b0}}, tally_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_q      <= '0;
      snap_q      <= '0;
      head_q      <= '0;
      fis_q       <= 1'b0;
      shift_q     <= 1'b0;
      stop_q      <= 1'b0;
      tally_q     <= TallyOne;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        tail_q  <= tail_d;
        snap_q  <= snap_d;
        head_q  <= head_d;
        fis_q   <= fis_d;
        shift_q <= shift_d;
        stop_q  <= stop_d;
        tally_q <= tally_d;
      end
      if (pop && entry_i.last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && entry_i.last) begin
      nmd_q <= nmd_d;
      fs_q  <= shift_d;
      gs_q  <= stop_d;
      cnt_q <= tally_ext[nmdc_pkg::CountW-1:0];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign nmd_target_o   = nmd_q;
  assign frame_shift_o  = fs_q;
  assign genomic_stop_o = gs_q;
  assign exon_count_o   = cnt_q;

endmodule

>>> hw/rtl/transcript_block_nmd_check_core.sv
// top level of the transcript block nmd check
// path: front stage-one registers, then the queue, then the back end result register
// throughput: one block per cycle while the result output is not stalled
// a two-entry queue between classifier and accumulator absorbs output stalls
// reset: asynchronous, active low; clears context, queue and output valid
// registers return to 55 minimum bases and a 16 base intron threshold
`timescale 1ns / 1ps

module transcript_block_nmd_check_core #(
  parameter int unsigned MaxExons   = nmdc_pkg::MaxExonsDef,
  parameter int unsigned QueueDepth = nmdc_pkg::QueueDepthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [0:0]   cfg_idx_i,
  input  logic [15:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // transcript_start[30:0] coding_start[61:31] coding_end[92:62]
  // block_offset[123:93] block_size[154:124] zero fill[159:155]
  input  logic [159:0] s_axis_tdata,
  input  logic         s_axis_tlast,
  // plus_strand[0]
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // nmd_target[0] frame_shift[1] genomic_stop[2] exon_count[15:3]
  output logic [15:0]  m_axis_tdata
);

  logic [nmdc_pkg::CfgW-1:0] nmd_min_q, gap_min_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nmd_min_q <= nmdc_pkg::NmdMinReset;
      gap_min_q <= nmdc_pkg::IntronGapReset;
    end else if (cfg_we_i) begin
      unique case (nmdc_pkg::cfg_idx_e'(cfg_idx_i))
        nmdc_pkg::CfgNmdMinBases:  nmd_min_q <= cfg_data_i;
        nmdc_pkg::CfgIntronMinGap: gap_min_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic             f_valid, f_ready, b_valid, b_ready;
  nmdc_pkg::entry_t f_entry, b_entry;

  nmdc_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (s_axis_tvalid),
    .in_ready_o         (s_axis_tready),
    .transcript_start_i (s_axis_tdata[30:0]),
    .coding_start_i     (s_axis_tdata[61:31]),
    .coding_end_i       (s_axis_tdata[92:62]),
    .plus_strand_i      (s_axis_tuser),
    .block_offset_i     (s_axis_tdata[123:93]),
    .block_size_i       (s_axis_tdata[154:124]),
    .last_block_i       (s_axis_tlast),
    .intron_min_gap_i   (gap_min_q),
    .entry_valid_o      (f_valid),
    .entry_ready_i      (f_ready),
    .entry_o            (f_entry)
  );

  nmdc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_entry),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (b_entry)
  );

  nmdc_back #(
    .MaxExons (MaxExons)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .entry_valid_i   (b_valid),
    .entry_ready_o   (b_ready),
    .entry_i         (b_entry),
    .nmd_min_bases_i (nmd_min_q),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .nmd_target_o    (m_axis_tdata[0]),
    .frame_shift_o   (m_axis_tdata[1]),
    .genomic_stop_o  (m_axis_tdata[2]),
    .exon_count_o    (m_axis_tdata[15:3])
  );

endmodule

>>> hw/rtl/nmdc_checker.sv
// port-level checker for the transcript block nmd check, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nmdc_checker #(
  parameter int unsigned MaxExons = nmdc_pkg::MaxExonsDef
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  localparam bit CountWraps = MaxExons >= 8192;

  `NMDC_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
  `NMDC_ASSERT_NR(a_reset_idle, clk_i, !rst_ni |=> !m_axis_tvalid, "result valid during reset")
  `NMDC_ASSERT(a_count_nonzero, clk_i, rst_ni, m_axis_tvalid |-> CountWraps || (m_axis_tdata[15:3] != 13'd0), "exon count of zero")
  `NMDC_ASSERT(a_count_max, clk_i, rst_ni, m_axis_tvalid |-> CountWraps || ({19'd0, m_axis_tdata[15:3]} <= 32'(MaxExons)), "exon count above its limit")

endmodule

bind transcript_block_nmd_check_core nmdc_checker #(
  .MaxExons (MaxExons)
) u_nmdc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> test/transcript_block_nmd_check_core_test.sv
// self-checking testbench for the transcript block nmd check core
`timescale 1ns / 1ps

module transcript_block_nmd_check_core_test;

  typedef struct packed {
    logic [30:0] tstart;
    logic [30:0] cstart;
    logic [30:0] cend;
    logic        plus;
    logic [30:0] off;
    logic [30:0] len;
    logic        last;
  } block_t;

  typedef struct packed {
    logic        nmd;
    logic        shift;
    logic        stop;
    logic [12:0] exons;
  } verdict_t;

  typedef struct {
    block_t   blk;
    bit       typed;
    verdict_t want;
  } dir_row_t;

  localparam int unsigned PosMax = 32'h7FFF_FFFF;

  logic         clk_i;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [0:0]   cfg_idx_i = nmdc_pkg::CfgNmdMinBases;
  logic [15:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [15:0]  m_axis_tdata;

  // predictor context and register copies
  longint unsigned decay_min = 64'(nmdc_pkg::NmdMinReset);
  longint          intron_gap = 64'(nmdc_pkg::IntronGapReset);
  bit              nmd_mid = 0;
  longint unsigned hold_start = 0, hold_cs = 0, hold_ce = 0;
  bit              hold_plus = 0;
  longint unsigned prev_end = 0, tail_sum = 0, tail_snap = 0, head_sum = 0;
  bit              intron_seen = 0, shift_seen = 0, stop_seen = 0;
  int              exon_tally = 1;

  verdict_t verdict_q[$];
  dir_row_t dir_rows[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors = 0;
  int blocks_sent = 0;
  int verdicts_seen = 0;
  int decay_flags = 0;

  transcript_block_nmd_check_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("transcript_block_nmd_check_core_test failed");
    $finish;
  end

  function automatic longint unsigned sum_sat(longint unsigned a, longint unsigned b);
    return (a + b > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : a + b;
  endfunction

  task automatic track_block(input block_t b, output bit done, output verdict_t v);
    longint unsigned off64, end64, s, e, lo, hi, bases;
    longint gap;
    off64 = 64'(b.off);
    end64 = off64 + 64'(b.len);
    done = 0;
    v = '0;
    if (!nmd_mid) begin
      hold_start = 64'(b.tstart);
      hold_cs = 64'(b.cstart);
      hold_ce = 64'(b.cend);
      hold_plus = b.plus;
      tail_sum = 0;
      tail_snap = 0;
      intron_seen = 0;
      head_sum = 0;
      shift_seen = 0;
      stop_seen = 0;
      exon_tally = 1;
    end else begin
      gap = off64 - prev_end;
      if (gap == 1 || gap == 2) begin
        shift_seen = 1;
      end else if (gap == 3) begin
        stop_seen = 1;
      end else if (exon_tally < nmdc_pkg::MaxExonsDef) begin
        exon_tally++;
      end
      if (gap > intron_gap) begin
        if (hold_plus) begin
          if (hold_ce < hold_start + prev_end) begin
            tail_snap = tail_sum;
            intron_seen = 1;
          end
        end else if (!intron_seen && hold_start + off64 < hold_cs) begin
          intron_seen = 1;
        end
      end
    end
    s = hold_start + off64;
    e = hold_start + end64;
    if (hold_plus) begin
      lo = (s > hold_ce) ? s : hold_ce;
      if (e > lo) tail_sum = sum_sat(tail_sum, e - lo);
    end else if (intron_seen) begin
      hi = (e < hold_cs) ? e : hold_cs;
      if (hi > s) head_sum = sum_sat(head_sum, hi - s);
    end
    prev_end = end64 & 64'hFFFF_FFFF;
    if (!b.last) begin
      nmd_mid = 1;
    end else begin
      nmd_mid = 0;
      done = 1;
      bases = hold_plus ? tail_snap : head_sum;
      v.nmd = (hold_cs < hold_ce) && intron_seen && (bases >= decay_min);
      v.shift = shift_seen;
      v.stop = stop_seen;
      v.exons = exon_tally[12:0];
    end
  endtask

  task automatic send_block(input block_t b, input bit typed, input verdict_t want);
    bit done;
    verdict_t v;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'b0, b.len, b.off, b.cend, b.cstart, b.tstart};
    s_axis_tuser <= b.plus;
    s_axis_tlast <= b.last;
    do @(posedge clk_i); while (!s_axis_tready);
    blocks_sent++;
    track_block(b, done, v);
    if (done) verdict_q.push_back(typed ? want : v);
  endtask

  task automatic send_transcript(input int nblk, input bit noise, input bit all_introns);
    block_t blks[$];
    block_t b;
    longint unsigned pos, span, c1, c2;
    int k, kind;
    pos = 0;
    for (k = 0; k < nblk; k++) begin
      b.tstart = 31'($urandom());
      b.cstart = 31'($urandom());
      b.cend = 31'($urandom());
      b.plus = 1'($urandom());
      if (noise) begin
        b.off = 31'($urandom());
        b.len = 31'($urandom());
      end else begin
        if (k > 0) begin
          kind = all_introns ? 9 : $urandom_range(9);
          case (kind)
            0: pos += $urandom_range(1, 2);
            1: pos += 3;
            2: pos -= $urandom_range(0, 32'((pos < 60) ? pos : 60));
            3: pos += $urandom_range(4, 16);
            4: pos += intron_gap;
            5: pos += intron_gap + 1;
            default: pos += intron_gap + $urandom_range(1, 5000);
          endcase
        end
        b.off = 31'(pos);
        b.len = 31'(($urandom_range(19) == 0) ? $urandom_range(4000) : $urandom_range(300));
        pos += b.len;
      end
      b.last = (k == nblk - 1);
      blks.push_back(b);
    end
    if (!noise) begin
      span = pos + 1;
      blks[0].tstart = 31'(($urandom_range(7) == 0) ? $urandom()
                                                   : $urandom_range(32'h3FFF_FFFF));
      c1 = blks[0].tstart + $urandom_range(32'(span));
      c2 = blks[0].tstart + $urandom_range(32'(span));
      if (c1 > c2 && $urandom_range(7) != 0) begin
        blks[0].cstart = 31'(c2);
        blks[0].cend = 31'(c1);
      end else begin
        blks[0].cstart = 31'(c1);
        blks[0].cend = 31'(c2);
      end
    end
    foreach (blks[i]) send_block(blks[i], 1'b0, '0);
  endtask

  task automatic set_regs(input logic [15:0] min_bases, input logic [15:0] gap_min);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= nmdc_pkg::CfgNmdMinBases;
    cfg_data_i <= min_bases;
    @(posedge clk_i);
    decay_min = 64'(min_bases);
    cfg_idx_i <= nmdc_pkg::CfgIntronMinGap;
    cfg_data_i <= gap_min;
    @(posedge clk_i);
    intron_gap = 64'(gap_min);
    cfg_we_i <= 1'b0;
  endtask

  function automatic dir_row_t blk_row(int unsigned ts, int unsigned cs, int unsigned ce,
                                       int unsigned pl, int unsigned of, int unsigned ln,
                                       int unsigned la, int unsigned typed, verdict_t want);
    dir_row_t r;
    r.blk = '{31'(ts), 31'(cs), 31'(ce), 1'(pl), 31'(of), 31'(ln), 1'(la)};
    r.typed = 1'(typed);
    r.want = want;
    return r;
  endfunction

  function automatic void cmp_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // result side: random back-pressure and comparison
  always @(posedge clk_i) begin
    verdict_t want;
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (verdict_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction, actual %h", $time, m_axis_tdata);
      end else begin
        want = verdict_q.pop_front();
        verdicts_seen++;
        if (m_axis_tdata[0]) decay_flags++;
        cmp_field("nmd_target", int'(want.nmd), int'(m_axis_tdata[0]));
        cmp_field("frame_shift", int'(want.shift), int'(m_axis_tdata[1]));
        cmp_field("genomic_stop", int'(want.stop), int'(m_axis_tdata[2]));
        cmp_field("exon_count", int'(want.exons), int'(m_axis_tdata[15:3]));
      end
    end
  end

  initial begin
    int ph, goal;
    // single block
    dir_rows.push_back(blk_row(1000, 1010, 1100, 1, 0, 200, 1, 1,
                               verdict_t'{1'b0, 1'b0, 1'b0, 13'd1}));
    // gaps of 1, 2 and 3 bases
    dir_rows.push_back(blk_row(0, 5, 50, 0, 0, 10, 0, 0, '0));
    dir_rows.push_back(blk_row(PosMax, PosMax, PosMax, 1, 11, 10, 0, 0, '0));
    dir_rows.push_back(blk_row(PosMax, PosMax, PosMax, 0, 23, 10, 0, 0, '0));
    dir_rows.push_back(blk_row(PosMax, PosMax, PosMax, 1, 36, 5, 1, 1,
                               verdict_t'{1'b0, 1'b1, 1'b1, 13'd1}));
    // plus strand decay target
    dir_rows.push_back(blk_row(0, 10, 100, 1, 0, 200, 0, 0, '0));
    dir_rows.push_back(blk_row(PosMax, PosMax, PosMax, 0, 300, 50, 1, 1,
                               verdict_t'{1'b1, 1'b0, 1'b0, 13'd2}));
    // minus strand decay target
    dir_rows.push_back(blk_row(0, 1000, 2000, 0, 0, 10, 0, 0, '0));
    dir_rows.push_back(blk_row(PosMax, PosMax, PosMax, 1, 100, 100, 0, 0, '0));
    dir_rows.push_back(blk_row(PosMax, PosMax, PosMax, 1, 500, 10, 1, 1,
                               verdict_t'{1'b1, 1'b0, 1'b0, 13'd3}));
    // non-coding transcript never flagged
    dir_rows.push_back(blk_row(0, 100, 100, 1, 0, 200, 0, 0, '0));
    dir_rows.push_back(blk_row(PosMax, PosMax, PosMax, 1, 300, 50, 1, 1,
                               verdict_t'{1'b0, 1'b0, 1'b0, 13'd2}));
    // zero and negative gaps
    dir_rows.push_back(blk_row(0, 0, 500, 1, 100, 0, 0, 0, '0));
    dir_rows.push_back(blk_row(PosMax, PosMax, PosMax, 0, 100, 50, 0, 0, '0));
    dir_rows.push_back(blk_row(PosMax, PosMax, PosMax, 1, 20, 5, 1, 1,
                               verdict_t'{1'b0, 1'b0, 1'b0, 13'd3}));
    // field extremes
    dir_rows.push_back(blk_row(PosMax, 0, PosMax, 1, PosMax, PosMax, 1, 1,
                               verdict_t'{1'b0, 1'b0, 1'b0, 13'd1}));
    dir_rows.push_back(blk_row(0, 0, 0, 0, 0, 0, 1, 1,
                               verdict_t'{1'b0, 1'b0, 1'b0, 13'd1}));
    // saturating tail sum, then an intron past the coding end
    dir_rows.push_back(blk_row(0, 0, 1, 1, 0, PosMax, 0, 0, '0));
    dir_rows.push_back(blk_row(PosMax, PosMax, PosMax, 0, 0, PosMax, 0, 0, '0));
    dir_rows.push_back(blk_row(PosMax, PosMax, PosMax, 0, 0, PosMax, 0, 0, '0));
    dir_rows.push_back(blk_row(PosMax, PosMax, PosMax, 0, 0, 100, 0, 0, '0));
    dir_rows.push_back(blk_row(PosMax, PosMax, PosMax, 0, 200, 10, 1, 0, '0));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (ph = 0; ph < 6; ph++) begin
      if (ph < 2) begin
        send_idle_pct = 27;
        recv_idle_pct = 51;
      end else if (ph < 4) begin
        send_idle_pct = 51;
        recv_idle_pct = 27;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (ph)
        1: set_regs(16'd0, 16'd0);
        2: set_regs(16'hFFFF, 16'hFFFF);
        3: set_regs(16'($urandom_range(200)), 16'($urandom_range(64)));
        4: set_regs(16'd1, 16'd3);
        5: set_regs(16'($urandom()), 16'($urandom()));
        default: ;
      endcase
      if (ph == 0) begin
        foreach (dir_rows[i]) send_block(dir_rows[i].blk, dir_rows[i].typed, dir_rows[i].want);
      end
      goal = blocks_sent + 125;
      while (blocks_sent < goal) begin
        send_transcript(($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6),
                        $urandom_range(9) == 0, 1'b0);
      end
      s_axis_tvalid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clk_i);
      repeat (8) @(posedge clk_i);
    end

    $display("checked %0d transcript results (%0d decay flags) from %0d blocks",
             verdicts_seen, decay_flags, blocks_sent);
    $display("six register settings, extremes included, under three idle patterns");
    if (errors == 0) begin
      $display("transcript_block_nmd_check_core_test passed");
    end else begin
      $display("transcript_block_nmd_check_core_test failed");
    end
    $finish;
  end

endmodule
